[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

[sv/tnu_pkg.sv]
// ----------------------------------------------------------------------------
// Triangle unit normal package
// Widths, pipeline stage indexes and shared helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package tnu_pkg;

    localparam int COORD_BITS = 24;
    localparam int FRAC_BITS  = 15;
    localparam int OUT_BITS   = 16;

    localparam int D_W      = COORD_BITS + 1;       // edge vector component
    localparam int P_W      = 2 * D_W;              // partial product
    localparam int N_W      = P_W + 1;              // cross product component
    localparam int POS_W    = $clog2(N_W);
    localparam int NORM_TOP = 30;                   // leading one lands here
    localparam int M_W      = NORM_TOP + 1;
    localparam int WIDE_W   = N_W + NORM_TOP;
    localparam int SQ_W     = 2 * M_W;
    localparam int S_W      = SQ_W + 2;
    localparam int R_W      = S_W / 2;              // root width
    localparam int RM_W     = R_W + 2;              // root remainder
    localparam int SQ_STEPS = R_W;
    localparam int QB       = FRAC_BITS + 1;        // quotient bits
    localparam int NUM_W    = M_W + FRAC_BITS + 1;

    localparam int ST_D    = 0;
    localparam int ST_P    = 1;
    localparam int ST_N    = 2;
    localparam int ST_POS  = 3;
    localparam int ST_SH   = 4;
    localparam int ST_SQR  = 5;
    localparam int ST_SUM  = 6;
    localparam int ST_RT0  = 7;
    localparam int ST_PREP = ST_RT0 + SQ_STEPS;
    localparam int ST_DV0  = ST_PREP + 1;
    localparam int NST     = ST_DV0 + QB;

    typedef struct packed {
        logic [2:0]          neg;
        logic                deg;
        logic [2:0][M_W-1:0] m;
    } side_t;

    typedef struct packed {
        side_t            side;
        logic [S_W-1:0]   s;
        logic [RM_W-1:0]  rem;
        logic [R_W-1:0]   root;
    } rt_t;

    typedef struct packed {
        logic [2:0]            neg;
        logic                  deg;
        logic [R_W-1:0]        len;
        logic [2:0][NUM_W-1:0] num;
        logic [2:0][R_W-1:0]   rem;
        logic [2:0][QB-1:0]    q;
    } dv_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] nx;
        logic [OUT_BITS-1:0] ny;
        logic [OUT_BITS-1:0] nz;
        logic                deg;
    } res_t;

    function automatic logic [POS_W-1:0] lead_pos(input logic [N_W-1:0] v);
        logic [POS_W-1:0] p;
        p = '0;
        for (int i = 0; i < N_W; i++)
        begin
            if (v[i])
                p = POS_W'(i);
        end
        return p;
    endfunction

endpackage

`default_nettype wire

[sv/triangle_unit_normal.sv]
// ----------------------------------------------------------------------------
// Triangle unit normal
// Cross product of two triangle edges scaled to a signed Q1.15 unit vector.
// ----------------------------------------------------------------------------
// Fully pipelined: one triangle per cycle while the pipeline is not stalled.
// An accepted input transaction is loaded into the output register through
// 57 register stages (7 front stages, 32 one-bit square root stages, one prep
// stage, 16 one-bit divide stages running three lanes side by side, then the
// output buffer). A two-entry output buffer lets the pipeline keep accepting
// while a result waits; the pipeline stalls only once both entries are full
// and out_ready is low. A triangle whose cross product is zero gives zero
// components with degenerate set.
`default_nettype none
`include "assert_macros.svh"

module triangle_unit_normal
    import tnu_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [COORD_BITS-1:0] ax,
    input  wire logic signed [COORD_BITS-1:0] ay,
    input  wire logic signed [COORD_BITS-1:0] az,
    input  wire logic signed [COORD_BITS-1:0] bx,
    input  wire logic signed [COORD_BITS-1:0] by,
    input  wire logic signed [COORD_BITS-1:0] bz,
    input  wire logic signed [COORD_BITS-1:0] cx,
    input  wire logic signed [COORD_BITS-1:0] cy,
    input  wire logic signed [COORD_BITS-1:0] cz,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [OUT_BITS-1:0]        nx,
    output logic signed [OUT_BITS-1:0]        ny,
    output logic signed [OUT_BITS-1:0]        nz,
    output logic                              degenerate
);

    localparam logic [QB-1:0] Q_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic           adv;
    logic [NST-1:0] vld_reg;

    // front stages
    logic signed [D_W-1:0] d0_reg [3];
    logic signed [D_W-1:0] d1_reg [3];
    logic signed [P_W-1:0] p_reg [6];
    logic signed [N_W-1:0] n_next [3];
    logic [N_W-1:0]        mag_reg [3];
    logic [2:0]            neg_reg;
    logic [N_W-1:0]        mag3_reg [3];
    logic [2:0]            neg3_reg;
    logic [POS_W-1:0]      pos_reg;
    logic                  deg3_reg;
    side_t                 sh_next;
    side_t                 sh_reg;
    logic [SQ_W-1:0]       sqr_reg [3];
    side_t                 side5_reg;
    logic [S_W-1:0]        sum_reg;
    side_t                 side6_reg;

    rt_t rt_in   [SQ_STEPS];
    rt_t rt_next [SQ_STEPS];
    rt_t rt_reg  [SQ_STEPS];

    dv_t prep_next;
    dv_t prep_reg;
    dv_t dv_in   [QB];
    dv_t dv_next [QB];
    dv_t dv_reg  [QB];

    // output buffer
    res_t       res_next;
    res_t       ob0_reg;
    res_t       ob1_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign adv      = (cnt_reg != 2'd2) || out_ready;
    assign in_ready = adv;
    assign push     = vld_reg[NST-1] && adv;
    assign pop      = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NST-2:0], in_valid};
    end

    always_comb
    begin
        n_next[0] = N_W'(p_reg[0]) - N_W'(p_reg[1]);
        n_next[1] = N_W'(p_reg[2]) - N_W'(p_reg[3]);
        n_next[2] = N_W'(p_reg[4]) - N_W'(p_reg[5]);
    end

    always_comb
    begin
        sh_next.neg = neg3_reg;
        sh_next.deg = deg3_reg;
        for (int i = 0; i < 3; i++)
            sh_next.m[i] = M_W'({mag3_reg[i], {NORM_TOP{1'b0}}} >> pos_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d0_reg[0] <= D_W'(bx) - D_W'(ax);
            d0_reg[1] <= D_W'(by) - D_W'(ay);
            d0_reg[2] <= D_W'(bz) - D_W'(az);
            d1_reg[0] <= D_W'(cx) - D_W'(ax);
            d1_reg[1] <= D_W'(cy) - D_W'(ay);
            d1_reg[2] <= D_W'(cz) - D_W'(az);

            p_reg[0] <= d0_reg[1] * d1_reg[2];
            p_reg[1] <= d0_reg[2] * d1_reg[1];
            p_reg[2] <= d0_reg[2] * d1_reg[0];
            p_reg[3] <= d0_reg[0] * d1_reg[2];
            p_reg[4] <= d0_reg[0] * d1_reg[1];
            p_reg[5] <= d0_reg[1] * d1_reg[0];

            for (int i = 0; i < 3; i++)
            begin
                neg_reg[i] <= n_next[i][N_W-1];
                mag_reg[i] <= n_next[i][N_W-1] ? N_W'(-n_next[i]) : N_W'(n_next[i]);
            end

            // leading one of the OR equals that of the largest magnitude
            pos_reg  <= lead_pos(mag_reg[0] | mag_reg[1] | mag_reg[2]);
            deg3_reg <= (mag_reg[0] | mag_reg[1] | mag_reg[2]) == '0;
            mag3_reg <= mag_reg;
            neg3_reg <= neg_reg;

            sh_reg <= sh_next;

            for (int i = 0; i < 3; i++)
                sqr_reg[i] <= SQ_W'(sh_reg.m[i]) * SQ_W'(sh_reg.m[i]);
            side5_reg <= sh_reg;

            sum_reg   <= S_W'(sqr_reg[0]) + S_W'(sqr_reg[1]) + S_W'(sqr_reg[2]);
            side6_reg <= side5_reg;
        end
    end

    // square root, one root bit per stage
    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_rt
        localparam int PI = SQ_STEPS - 1 - k;
        logic [RM_W+1:0] tmp;
        logic [RM_W+1:0] trial;

        if (k == 0)
        begin : g_first
            always_comb
            begin
                rt_in[k].side = side6_reg;
                rt_in[k].s    = sum_reg;
                rt_in[k].rem  = '0;
                rt_in[k].root = '0;
            end
        end
        else
        begin : g_rest
            assign rt_in[k] = rt_reg[k-1];
        end

        always_comb
        begin
            tmp     = {rt_in[k].rem, rt_in[k].s[2*PI+1 -: 2]};
            trial   = (RM_W+2)'({rt_in[k].root, 2'b01});
            rt_next[k] = rt_in[k];
            if (tmp >= trial)
            begin
                rt_next[k].rem  = RM_W'(tmp - trial);
                rt_next[k].root = {rt_in[k].root[R_W-2:0], 1'b1};
            end
            else
            begin
                rt_next[k].rem  = RM_W'(tmp);
                rt_next[k].root = {rt_in[k].root[R_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                rt_reg[k] <= rt_next[k];
        end
    end

    // numerators carry the half-divisor rounding term
    always_comb
    begin
        prep_next.neg = rt_reg[SQ_STEPS-1].side.neg;
        prep_next.deg = rt_reg[SQ_STEPS-1].side.deg;
        prep_next.len = rt_reg[SQ_STEPS-1].root;
        prep_next.q   = '0;
        for (int i = 0; i < 3; i++)
        begin
            prep_next.num[i] = (NUM_W'(rt_reg[SQ_STEPS-1].side.m[i]) << FRAC_BITS)
                             + NUM_W'(rt_reg[SQ_STEPS-1].root >> 1);
            prep_next.rem[i] = R_W'(prep_next.num[i][NUM_W-1:QB]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            prep_reg <= prep_next;
    end

    // restoring divide, one quotient bit per stage, three lanes
    for (genvar k = 0; k < QB; k++)
    begin : g_dv
        localparam int J = QB - 1 - k;
        logic [R_W:0] t [3];

        if (k == 0)
        begin : g_first
            assign dv_in[k] = prep_reg;
        end
        else
        begin : g_rest
            assign dv_in[k] = dv_reg[k-1];
        end

        always_comb
        begin
            dv_next[k] = dv_in[k];
            for (int i = 0; i < 3; i++)
            begin
                t[i] = {dv_in[k].rem[i], dv_in[k].num[i][J]};
                if (t[i] >= {1'b0, dv_in[k].len})
                begin
                    dv_next[k].rem[i]  = R_W'(t[i] - {1'b0, dv_in[k].len});
                    dv_next[k].q[i][J] = 1'b1;
                end
                else
                begin
                    dv_next[k].rem[i]  = R_W'(t[i]);
                    dv_next[k].q[i][J] = 1'b0;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                dv_reg[k] <= dv_next[k];
        end
    end

    // sign and saturation; only +1.0 is clipped
    always_comb
    begin
        logic [QB:0]         qe;
        logic [QB:0]         rs;
        logic [OUT_BITS-1:0] comp [3];
        for (int i = 0; i < 3; i++)
        begin
            qe = {1'b0, dv_reg[QB-1].q[i]};
            if (dv_reg[QB-1].neg[i])
                rs = -qe;
            else if (dv_reg[QB-1].q[i] == Q_ONE)
                rs = qe - (QB+1)'(1);
            else
                rs = qe;
            comp[i] = dv_reg[QB-1].deg ? '0 : OUT_BITS'($signed(rs));
        end
        res_next.nx  = comp[0];
        res_next.ny  = comp[1];
        res_next.nz  = comp[2];
        res_next.deg = dv_reg[QB-1].deg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (cnt_reg == 2'd2)
        begin
            if (pop)
            begin
                ob0_reg <= ob1_reg;
                if (push)
                    ob1_reg <= res_next;
            end
        end
        else if (cnt_reg == 2'd1)
        begin
            if (push && pop)
                ob0_reg <= res_next;
            else if (push)
                ob1_reg <= res_next;
        end
        else if (push)
        begin
            ob0_reg <= res_next;
        end
    end

    assign out_valid  = cnt_reg != 2'd0;
    assign nx         = ob0_reg.nx;
    assign ny         = ob0_reg.ny;
    assign nz         = ob0_reg.nz;
    assign degenerate = ob0_reg.deg;

    `ASSERT_HOLDS(a_deg_zero, clk, rst_n, out_valid && degenerate |-> nx == '0 && ny == '0 && nz == '0, "degenerate result with nonzero component")
    `ASSERT_HOLDS(a_norm_top, clk, rst_n, vld_reg[ST_SH] && !sh_reg.deg |-> (sh_reg.m[0][M_W-1] || sh_reg.m[1][M_W-1] || sh_reg.m[2][M_W-1]), "normalization missed leading one")
    `ASSERT_HOLDS(a_len_range, clk, rst_n, vld_reg[ST_PREP] && !prep_reg.deg |-> prep_reg.len[R_W-1:NORM_TOP] != '0, "vector length below normalized range")
    `ASSERT_NEVER(a_buf_over, clk, rst_n, cnt_reg == 2'd3, "output buffer count out of range")

endmodule

`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Triangle unit normal testbench
// Drives triangles through the valid/ready input, predicts the Q1.15 unit
// normal of each accepted transaction, and checks every output transaction
// in order. Directed table first, then random triangles with idle bursts,
// a long output hold-off and a drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module testbench;
    import tnu_pkg::*;

    localparam int LATENCY   = 57;
    localparam int N_RANDOM  = 1750;
    localparam int MAX_CYCLE = 400000;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] nx;
        logic [OUT_BITS-1:0] ny;
        logic [OUT_BITS-1:0] nz;
        logic                deg;
    } normal_t;

    // directed row: corners, a flag telling whether the expected value is typed in
    typedef struct {
        coord_t  v [9];
        bit      typed;
        normal_t want;
    } tri_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    coord_t ax, ay, az, bx, by, bz, cx, cy, cz;
    logic out_valid;
    logic out_ready;
    logic signed [OUT_BITS-1:0] nx, ny, nz;
    logic degenerate;

    normal_t normal_q[$];
    int      errors;
    int      cycle;
    bit      quiet;        // no idling in the last part of the run
    bit      hold_out;     // long receiver hold-off in progress

    triangle_unit_normal DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .ax(ax), .ay(ay), .az(az), .bx(bx), .by(by), .bz(bz),
        .cx(cx), .cy(cy), .cz(cz),
        .out_valid(out_valid), .out_ready(out_ready),
        .nx(nx), .ny(ny), .nz(nz), .degenerate(degenerate)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] s);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > s)
            b = b >> 2;
        while (b != 0)
        begin
            if (s >= res + b)
            begin
                s = s - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic normal_t unit_normal(input coord_t v [9]);
        logic signed [63:0] d0 [3];
        logic signed [63:0] d1 [3];
        logic signed [63:0] n [3];
        logic [63:0] m [3];
        logic [63:0] mx, s, len, q, one;
        logic [OUT_BITS-1:0] comp [3];
        normal_t r;
        for (int i = 0; i < 3; i++)
        begin
            d0[i] = 64'(v[3+i]) - 64'(v[i]);
            d1[i] = 64'(v[6+i]) - 64'(v[i]);
        end
        n[0] = d0[1] * d1[2] - d0[2] * d1[1];
        n[1] = d0[2] * d1[0] - d0[0] * d1[2];
        n[2] = d0[0] * d1[1] - d0[1] * d1[0];
        for (int i = 0; i < 3; i++)
            m[i] = n[i] < 0 ? -n[i] : n[i];
        mx = m[0];
        if (m[1] > mx) mx = m[1];
        if (m[2] > mx) mx = m[2];
        if (mx == 0)
            return '{nx: '0, ny: '0, nz: '0, deg: 1'b1};
        while (mx >= (64'd1 << 31))
        begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        end
        while (mx < (64'd1 << 30))
        begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        end
        s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        len = int_sqrt(s);
        one = 64'd1 << FRAC_BITS;
        for (int i = 0; i < 3; i++)
        begin
            q = ((m[i] << FRAC_BITS) + (len >> 1)) / len;
            if (q > one) q = one;
            if (n[i] < 0)
                comp[i] = OUT_BITS'(-q);
            else
                comp[i] = OUT_BITS'(q == one ? one - 1 : q);
        end
        r.nx = comp[0];
        r.ny = comp[1];
        r.nz = comp[2];
        r.deg = 1'b0;
        return r;
    endfunction

    // Drops valid for a random gap; called at a falling edge.
    task automatic idle_burst();
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
    endtask

    // Presents one triangle and waits for its acceptance.
    task automatic send_triangle(input coord_t v [9]);
        ax <= v[0]; ay <= v[1]; az <= v[2];
        bx <= v[3]; by <= v[4]; bz <= v[5];
        cx <= v[6]; cy <= v[7]; cz <= v[8];
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        normal_q.insert(normal_q.size(), unit_normal(v));
        @(negedge clk);
    endtask

    function automatic coord_t rand_coord(input int mode);
        case (mode)
            0: return coord_t'($urandom);
            1: return coord_t'($signed($urandom_range(0, 40)) - 20);
            2: return $urandom_range(0, 1) ? coord_t'(24'h7fffff - $urandom_range(0, 3))
                                           : coord_t'(24'h800000 + $urandom_range(0, 3));
            default: return coord_t'($signed($urandom_range(0, 4000)) - 2000);
        endcase
    endfunction

    // Receiver: random stalls, plus one long hold-off requested by the sender.
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_out)
                out_ready <= 1'b0;
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7) - 1) @(negedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Output checker
    always @(posedge clk)
    begin
        normal_t exp_n;
        if (rst_n && out_valid && out_ready)
        begin
            if (normal_q.size() == 0)
            begin
                $display("%0t: unexpected output transaction nx=%h ny=%h nz=%h deg=%b",
                         $time, nx, ny, nz, degenerate);
                errors++;
            end
            else
            begin
                exp_n = normal_q.pop_front();
                if (nx !== exp_n.nx || ny !== exp_n.ny || nz !== exp_n.nz
                    || degenerate !== exp_n.deg)
                begin
                    $display("%0t: mismatch expected nx=%h ny=%h nz=%h deg=%b actual nx=%h ny=%h nz=%h deg=%b",
                             $time, exp_n.nx, exp_n.ny, exp_n.nz, exp_n.deg,
                             nx, ny, nz, degenerate);
                    errors++;
                end
            end
        end
    end

    // Timeout
    always @(posedge clk)
    begin
        cycle++;
        if (cycle > MAX_CYCLE)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        tri_row_t rows [$];
        tri_row_t row;
        coord_t   v [9];
        coord_t   mx, mn;
        int       mode;

        errors = 0; cycle = 0; quiet = 0; hold_out = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        {ax, ay, az, bx, by, bz, cx, cy, cz} = '0;
        mx = 24'h7fffff;
        mn = 24'h800000;

        // Directed rows; typed expectations only where obvious.
        row.typed = 1; row.want = '{nx: '0, ny: '0, nz: '0, deg: 1'b1};
        row.v = '{0, 0, 0, 0, 0, 0, 0, 0, 0};       rows.insert(rows.size(), row);
        row.v = '{mx, mx, mx, mx, mx, mx, mx, mx, mx}; rows.insert(rows.size(), row);
        row.v = '{mn, mn, mn, mn, mn, mn, mn, mn, mn}; rows.insert(rows.size(), row);
        row.v = '{0, 0, 0, 1, 1, 1, 2, 2, 2};       rows.insert(rows.size(), row);   // collinear
        row.v = '{mn, mn, mn, 0, 0, 0, mx, mx, mx}; rows.insert(rows.size(), row);
        // +1.0 saturates, -1.0 kept
        row.want = '{nx: '0, ny: '0, nz: 16'h7fff, deg: 1'b0};
        row.v = '{0, 0, 0, 1, 0, 0, 0, 1, 0};       rows.insert(rows.size(), row);
        row.want = '{nx: '0, ny: '0, nz: 16'h8000, deg: 1'b0};
        row.v = '{0, 0, 0, 0, 1, 0, 1, 0, 0};       rows.insert(rows.size(), row);
        row.want = '{nx: 16'h7fff, ny: '0, nz: '0, deg: 1'b0};
        row.v = '{0, 0, 0, 0, 1, 0, 0, 0, 1};       rows.insert(rows.size(), row);
        row.want = '{nx: '0, ny: 16'h7fff, nz: '0, deg: 1'b0};
        row.v = '{0, 0, 0, 0, 0, 1, 1, 0, 0};       rows.insert(rows.size(), row);
        row.typed = 0;
        row.v = '{mn, mn, mn, mx, mn, mn, mn, mx, mn}; rows.insert(rows.size(), row);
        row.v = '{mx, mx, mx, mn, mx, mx, mx, mn, mx}; rows.insert(rows.size(), row);
        row.v = '{mn, mn, mn, mx, mx, mn, mn, mx, mx}; rows.insert(rows.size(), row);
        row.v = '{mx, mn, 0, mn, mx, mx, 0, mn, mx};  rows.insert(rows.size(), row);
        row.v = '{1, 2, 3, 4, 5, 6, 7, 8, 10};       rows.insert(rows.size(), row);
        row.v = '{0, 0, 0, 1, 1, 0, -1, 1, 0};       rows.insert(rows.size(), row);
        row.v = '{-5, 7, 9, 3, -2, 8, 6, 1, -4};     rows.insert(rows.size(), row);
        row.v = '{mx, 0, 0, 0, mx, 0, 0, 0, mx};     rows.insert(rows.size(), row);
        row.v = '{mn, 0, 0, 0, mn, 0, 0, 0, mn};     rows.insert(rows.size(), row);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[i])
        begin
            if (rows[i].typed && unit_normal(rows[i].v) !== rows[i].want)
            begin
                $display("%0t: table row %0d expected %h predicted %h",
                         $time, i, rows[i].want, unit_normal(rows[i].v));
                errors++;
            end
            send_triangle(rows[i].v);
            idle_burst();
        end

        for (int k = 0; k < N_RANDOM; k++)
        begin
            if (k == 300)
            begin
                // long output hold-off while triangles keep coming
                hold_out = 1;
                fork
                    begin
                        repeat (200) @(negedge clk);
                        hold_out = 0;
                    end
                join_none
            end
            if (k == 700)
            begin
                // sender pause: drain all results
                in_valid <= 1'b0;
                do
                    @(negedge clk);
                while (normal_q.size() != 0);
            end
            if (k == N_RANDOM - 200)
                quiet = 1;
            for (int j = 0; j < 9; j++)
            begin
                mode = $urandom_range(0, 3);
                v[j] = rand_coord(mode);
            end
            // some degenerate ones: third corner repeats the second or the first
            if ($urandom_range(0, 19) == 0)
                for (int j = 0; j < 3; j++) v[6+j] = v[3+j];
            else if ($urandom_range(0, 19) == 0)
                for (int j = 0; j < 3; j++) v[6+j] = v[j];
            send_triangle(v);
            if (!quiet) idle_burst();
        end

        in_valid <= 1'b0;
        while (normal_q.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

[triangle_unit_normal.f]
+incdir+sv
sv/tnu_pkg.sv
sv/triangle_unit_normal.sv
tb/testbench.sv
